// ===== src/tbw_pkg.sv =====
`timescale 1ns / 1ps

package tbw_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int W_BITS     = 32;

    // coordinate differences, products, cross product terms
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    // scaled numerator: (ux+uy) << FRAC_BITS
    localparam int NUM_W   = CROSS_W + 1 + FRAC_BITS;
    localparam int QS_W    = NUM_W + 2;
    localparam int LANES   = 3;

    localparam logic [W_BITS-1:0] ONE_W = W_BITS'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [CROSS_W-1:0] ux;
        logic signed [CROSS_W-1:0] uy;
        logic signed [CROSS_W-1:0] uz;
    } cross_t;

    typedef struct packed {
        logic                                deg;
        logic [LANES-1:0]                    neg;
        logic [CROSS_W-1:0]                  den;
        logic [LANES-1:0][CROSS_W-1:0]       rem;
        logic [LANES-1:0][NUM_W-1:0]         nq;
    } div_stage_t;

    // one restoring step: shift in next dividend bit, quotient bit to the lsb
    function automatic logic [CROSS_W+NUM_W-1:0] div_step(
        input logic [CROSS_W-1:0] rem,
        input logic [NUM_W-1:0]   nq,
        input logic [CROSS_W-1:0] den
    );
        logic [CROSS_W:0]   t;
        logic [CROSS_W:0]   d;
        logic               ge;
        logic [CROSS_W-1:0] rem_n;
        t     = {rem, nq[NUM_W-1]};
        d     = t - {1'b0, den};
        ge    = (t >= {1'b0, den});
        rem_n = ge ? d[CROSS_W-1:0] : t[CROSS_W-1:0];
        return {rem_n, nq[NUM_W-2:0], ge};
    endfunction

    function automatic logic [W_BITS-1:0] sat_w(input logic signed [QS_W-1:0] v);
        logic hi_same;
        hi_same = (v[QS_W-1:W_BITS-1] == {(QS_W-W_BITS+1){v[QS_W-1]}});
        if (hi_same) begin
            return v[W_BITS-1:0];
        end else if (v[QS_W-1]) begin
            return {1'b1, {(W_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(W_BITS-1){1'b1}}};
        end
    endfunction

endpackage

// ===== src/tbw_front.sv =====
`timescale 1ns / 1ps

module tbw_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] ax,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] ay,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] bx,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] by_coord,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] cx,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] cy,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] px,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] py,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output tbw_pkg::cross_t                       out_cross
);

    localparam int DW = tbw_pkg::DIFF_W;
    localparam int PW = tbw_pkg::PROD_W;

    logic                 v1_reg, v2_reg;
    logic                 rdy1, rdy2;
    logic signed [DW-1:0] x0_reg, x1_reg, x2_reg, y0_reg, y1_reg, y2_reg;
    logic signed [PW-1:0] p_x1y2_reg, p_x2y1_reg, p_x2y0_reg, p_x0y2_reg;
    logic signed [PW-1:0] p_x0y1_reg, p_x1y0_reg;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    // edge vectors
    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            x0_reg <= {cx[$high(cx)], cx} - {ax[$high(ax)], ax};
            x1_reg <= {bx[$high(bx)], bx} - {ax[$high(ax)], ax};
            x2_reg <= {ax[$high(ax)], ax} - {px[$high(px)], px};
            y0_reg <= {cy[$high(cy)], cy} - {ay[$high(ay)], ay};
            y1_reg <= {by_coord[$high(by_coord)], by_coord} - {ay[$high(ay)], ay};
            y2_reg <= {ay[$high(ay)], ay} - {py[$high(py)], py};
        end
    end

    // six partial products
    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            p_x1y2_reg <= x1_reg * y2_reg;
            p_x2y1_reg <= x2_reg * y1_reg;
            p_x2y0_reg <= x2_reg * y0_reg;
            p_x0y2_reg <= x0_reg * y2_reg;
            p_x0y1_reg <= x0_reg * y1_reg;
            p_x1y0_reg <= x1_reg * y0_reg;
        end
    end

    assign out_cross.ux = {p_x1y2_reg[PW-1], p_x1y2_reg} - {p_x2y1_reg[PW-1], p_x2y1_reg};
    assign out_cross.uy = {p_x2y0_reg[PW-1], p_x2y0_reg} - {p_x0y2_reg[PW-1], p_x0y2_reg};
    assign out_cross.uz = {p_x0y1_reg[PW-1], p_x0y1_reg} - {p_x1y0_reg[PW-1], p_x1y0_reg};

endmodule

// ===== src/tbw_queue.sv =====
`timescale 1ns / 1ps

module tbw_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  tbw_pkg::cross_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output tbw_pkg::cross_t rd_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    tbw_pkg::cross_t mem [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            wr_en, rd_en;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + AW'(1);
            if (rd_en) rp_reg <= rp_reg + AW'(1);
            if (wr_en && !rd_en)      cnt_reg <= cnt_reg + (AW+1)'(1);
            else if (rd_en && !wr_en) cnt_reg <= cnt_reg - (AW+1)'(1);
        end
    end

endmodule

// ===== src/tbw_back.sv =====
`timescale 1ns / 1ps

module tbw_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tbw_pkg::cross_t                 in_cross,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tbw_pkg::W_BITS-1:0]      m_weight_a,
    output logic [tbw_pkg::W_BITS-1:0]      m_weight_b,
    output logic [tbw_pkg::W_BITS-1:0]      m_weight_c,
    output logic                            m_degenerate
);

    localparam int UW = tbw_pkg::CROSS_W;
    localparam int NW = tbw_pkg::NUM_W;
    localparam int FB = tbw_pkg::FRAC_BITS;
    localparam int QW = tbw_pkg::QS_W;
    localparam int WB = tbw_pkg::W_BITS;
    localparam int NL = tbw_pkg::LANES;

    tbw_pkg::div_stage_t pipe_reg [NW+1];
    logic [NW:0]         pv_reg;
    logic                adv;

    logic                m_valid_reg, m_deg_reg;
    logic [WB-1:0]       wa_reg, wb_reg, wc_reg;

    // entry stage terms
    logic signed [UW:0]   sum_xy;
    logic signed [NW-1:0] num [NL];
    tbw_pkg::div_stage_t  entry;

    // whole back pipe moves when the output slot frees
    assign adv      = !m_valid_reg || m_ready;
    assign in_ready = adv;

    always_comb begin
        sum_xy = {in_cross.ux[UW-1], in_cross.ux} + {in_cross.uy[UW-1], in_cross.uy};
        num[0] = {sum_xy, {FB{1'b0}}};
        num[1] = {in_cross.uy[UW-1], in_cross.uy, {FB{1'b0}}};
        num[2] = {in_cross.ux[UW-1], in_cross.ux, {FB{1'b0}}};
        entry.deg = (in_cross.uz == '0);
        entry.den = in_cross.uz[UW-1] ? UW'(-in_cross.uz) : UW'(in_cross.uz);
        for (int l = 0; l < NL; l++) begin
            entry.neg[l] = num[l][NW-1] ^ in_cross.uz[UW-1];
            entry.rem[l] = '0;
            entry.nq[l]  = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
        end else if (adv) begin
            pv_reg <= {pv_reg[NW-1:0], in_valid};
        end
    end

    // one quotient bit per stage per lane
    always_ff @(posedge aclk) begin
        if (adv) begin
            pipe_reg[0] <= entry;
            for (int k = 1; k <= NW; k++) begin
                pipe_reg[k].deg <= pipe_reg[k-1].deg;
                pipe_reg[k].neg <= pipe_reg[k-1].neg;
                pipe_reg[k].den <= pipe_reg[k-1].den;
                for (int l = 0; l < NL; l++) begin
                    {pipe_reg[k].rem[l], pipe_reg[k].nq[l]} <=
                        tbw_pkg::div_step(pipe_reg[k-1].rem[l], pipe_reg[k-1].nq[l],
                                          pipe_reg[k-1].den);
                end
            end
        end
    end

    // sign fixup, weight_a = ONE - qa, saturate
    logic signed [QW-1:0] sq [NL];
    logic signed [QW-1:0] wa_full;

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            sq[l] = pipe_reg[NW].neg[l] ? -$signed({2'b00, pipe_reg[NW].nq[l]})
                                        :  $signed({2'b00, pipe_reg[NW].nq[l]});
        end
        wa_full = $signed(QW'(1) << FB) - sq[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= pv_reg[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_deg_reg <= pipe_reg[NW].deg;
            if (pipe_reg[NW].deg) begin
                wa_reg <= -tbw_pkg::ONE_W;
                wb_reg <= tbw_pkg::ONE_W;
                wc_reg <= tbw_pkg::ONE_W;
            end else begin
                wa_reg <= tbw_pkg::sat_w(wa_full);
                wb_reg <= tbw_pkg::sat_w(sq[1]);
                wc_reg <= tbw_pkg::sat_w(sq[2]);
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_degenerate = m_deg_reg;
    assign m_weight_a   = wa_reg;
    assign m_weight_b   = wb_reg;
    assign m_weight_c   = wc_reg;

endmodule

// ===== src/triangle_barycentric_weights_top.sv =====
`timescale 1ns / 1ps

// Barycentric weights of a point P in triangle ABC by the cross-product method.
// Input channel (s_*): one word carries the pixel coordinates of A, B, C and P.
// Output channel (m_*): one word per input, in order: weights of A, B, C as
//   signed fixed point with FRAC_BITS fraction bits, saturated to 32 bits, and
//   a degenerate flag (zero area; weights are then -1, 1, 1).
// Throughput: one word per cycle, sustained, as long as m_ready stays high.
// Path from input accept to output valid: two front stages
//   (edge differences, then six 13x13 multiplies), the queue, one entry stage,
//   44 restoring-division stages (one quotient bit per stage, three lanes
//   sharing the divisor |u.z|) and the output register.
// The front registers and a 4-word queue sit ahead of the divider pipe; when
//   m_ready is low the divider pipe and output register hold, the queue fills,
//   and then s_ready drops. No words are lost or repeated.
// Reset (aresetn low, synchronous) empties every stage and the queue; there
//   is no other state.
module triangle_barycentric_weights_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] s_ax,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] s_ay,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] s_bx,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] s_by_coord,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] s_cx,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] s_cy,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] s_px,
    input  logic signed [tbw_pkg::COORD_BITS-1:0] s_py,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [tbw_pkg::W_BITS-1:0]     m_weight_a,
    output logic signed [tbw_pkg::W_BITS-1:0]     m_weight_b,
    output logic signed [tbw_pkg::W_BITS-1:0]     m_weight_c,
    output logic                                  m_degenerate
);

    // front -> queue
    logic            f_valid, f_ready;
    tbw_pkg::cross_t f_cross;
    // queue -> back
    logic            q_valid, q_ready;
    tbw_pkg::cross_t q_cross;

    logic [tbw_pkg::W_BITS-1:0] wa, wb, wc;

    // edge vectors and cross product
    tbw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .ax        (s_ax),
        .ay        (s_ay),
        .bx        (s_bx),
        .by_coord  (s_by_coord),
        .cx        (s_cx),
        .cy        (s_cy),
        .px        (s_px),
        .py        (s_py),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_cross (f_cross)
    );

    // decouples front from the divider pipe
    tbw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cross),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cross)
    );

    // three pipelined dividers plus output register
    tbw_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_cross     (q_cross),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_weight_a   (wa),
        .m_weight_b   (wb),
        .m_weight_c   (wc),
        .m_degenerate (m_degenerate)
    );

    assign m_weight_a = $signed(wa);
    assign m_weight_b = $signed(wb);
    assign m_weight_c = $signed(wc);

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CW        = tbw_pkg::COORD_BITS;
    localparam int WW        = tbw_pkg::W_BITS;
    localparam int LATENCY   = 48;
    localparam int N_RANDOM  = 1500;
    localparam int STALL_MAX = 2000;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t ax, ay, bx, by_coord, cx, cy, px, py;
    } tri_word_t;

    typedef struct packed {
        logic [WW-1:0] wa, wb, wc;
        logic          deg;
    } weights_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_ax = '0, s_ay = '0, s_bx = '0, s_by_coord = '0;
    coord_t s_cx = '0, s_cy = '0, s_px = '0, s_py = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [WW-1:0] m_weight_a, m_weight_b, m_weight_c;
    logic m_degenerate;

    triangle_barycentric_weights_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tri_word_t pending_tris[$];
    weights_t  expected_weights[$];
    int  mismatches = 0;
    int  stall_cycles = 0;
    bit  stim_done = 1'b0;
    bit  quiet_tail = 1'b0;

    // Saturate a 64-bit value to the signed 32-bit weight range.
    function automatic logic [WW-1:0] clamp_w(input longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[WW-1:0];
    endfunction

    // Cross product of the edge vectors, then three truncating divides by u.z.
    function automatic weights_t barycentric(input tri_word_t t);
        longint ax, ay, bx, by, cx, cy, px, py, one;
        longint x0, x1, x2, y0, y1, y2, ux, uy, uz;
        weights_t r;
        ax = t.ax; ay = t.ay; bx = t.bx; by = t.by_coord;
        cx = t.cx; cy = t.cy; px = t.px; py = t.py;
        one = longint'(1) << tbw_pkg::FRAC_BITS;
        x0 = cx - ax; x1 = bx - ax; x2 = ax - px;
        y0 = cy - ay; y1 = by - ay; y2 = ay - py;
        ux = x1 * y2 - x2 * y1;
        uy = x2 * y0 - x0 * y2;
        uz = x0 * y1 - x1 * y0;
        if (uz == 0) begin
            r.wa = clamp_w(-one);
            r.wb = clamp_w(one);
            r.wc = clamp_w(one);
            r.deg = 1'b1;
        end else begin
            // SV integer division truncates toward zero
            r.wa = clamp_w(one - ((ux + uy) * one) / uz);
            r.wb = clamp_w((uy * one) / uz);
            r.wc = clamp_w((ux * one) / uz);
            r.deg = 1'b0;
        end
        return r;
    endfunction

    function automatic coord_t rand_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 31) - 16);   // tiny triangles
            2: return $urandom_range(1, 0) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return coord_t'($urandom_range(0, 255) - 128);
        endcase
    endfunction

    function automatic tri_word_t tri_of(input int a0, a1, b0, b1, c0, c1, p0, p1);
        tri_word_t t;
        t.ax = coord_t'(a0); t.ay = coord_t'(a1);
        t.bx = coord_t'(b0); t.by_coord = coord_t'(b1);
        t.cx = coord_t'(c0); t.cy = coord_t'(c1);
        t.px = coord_t'(p0); t.py = coord_t'(p1);
        return t;
    endfunction

    // Stimulus: directed corners first, then random triangles.
    initial begin
        tri_word_t t;
        int mode;
        int k;
        // plain triangle, point inside / on vertex / outside
        pending_tris.push_back(tri_of(0, 0, 10, 0, 0, 10, 3, 3));
        pending_tris.push_back(tri_of(0, 0, 10, 0, 0, 10, 0, 0));
        pending_tris.push_back(tri_of(0, 0, 10, 0, 0, 10, 10, 0));
        pending_tris.push_back(tri_of(0, 0, 10, 0, 0, 10, -500, 900));
        // degenerate: all zero, A = B = C with P apart, collinear
        pending_tris.push_back(tri_of(0, 0, 0, 0, 0, 0, 0, 0));
        pending_tris.push_back(tri_of(5, 5, 5, 5, 5, 5, 100, -3));
        pending_tris.push_back(tri_of(0, 0, 1, 1, 2, 2, 7, -9));
        // extremes of the coordinate range
        pending_tris.push_back(tri_of(-2048, -2048, 2047, -2048, -2048, 2047, 2047, 2047));
        pending_tris.push_back(tri_of(2047, 2047, -2048, 2047, 2047, -2048, -2048, -2048));
        pending_tris.push_back(tri_of(-2048, 2047, 2047, -2048, 2047, 2047, -2048, -2048));
        // tiny area, far point: large weights of both signs
        pending_tris.push_back(tri_of(0, 0, 1, 0, 0, 1, 2047, 2047));
        pending_tris.push_back(tri_of(0, 0, 1, 0, 0, 1, -2048, -2048));
        pending_tris.push_back(tri_of(0, 0, 0, 1, 1, 0, 2047, -2048));
        pending_tris.push_back(tri_of(0, 0, 1, 0, 1, 1, -2048, 2047));
        // negative area (clockwise), remainders of both signs, all points at -1
        pending_tris.push_back(tri_of(0, 0, 0, 7, 3, 0, 1, 1));
        pending_tris.push_back(tri_of(-3, 2, 5, -7, 11, 13, -1, 4));
        pending_tris.push_back(tri_of(1, 1, -1, -1, 1, -1, 0, 0));
        pending_tris.push_back(tri_of(-1, -1, -1, -1, -1, -1, -1, -1));
        for (k = 0; k < N_RANDOM; k++) begin
            mode = $urandom_range(0, 9);
            if (mode < 4) mode = 0;
            else if (mode < 6) mode = 1;
            else if (mode < 7) mode = 2;
            else mode = 3;
            t.ax = rand_coord(mode); t.ay = rand_coord(mode);
            t.bx = rand_coord(mode); t.by_coord = rand_coord(mode);
            t.cx = rand_coord(mode); t.cy = rand_coord(mode);
            t.px = rand_coord(mode); t.py = rand_coord(mode);
            // some collinear triangles: C on line AB
            if ($urandom_range(0, 19) == 0) begin
                t.cx = t.bx; t.cy = t.by_coord;
            end
            pending_tris.push_back(t);
        end
        stim_done = 1'b1;
    end

    int  src_idle = 0;
    int  sink_idle = 0;

    // Driver: keeps valid and the word steady until the handshake.
    always @(posedge aclk) begin
        tri_word_t t;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            quiet_tail <= pending_tris.size() < 150;
            if (s_valid && s_ready) begin
                expected_weights.push_back(barycentric({s_ax, s_ay, s_bx, s_by_coord,
                                                        s_cx, s_cy, s_px, s_py}));
            end
            if (!s_valid || s_ready) begin
                if (src_idle > 0) begin
                    src_idle <= src_idle - 1;
                    s_valid <= 1'b0;
                end else if (pending_tris.size() > 0 &&
                             !(!quiet_tail && $urandom_range(0, 15) == 0)) begin
                    t = pending_tris.pop_front();
                    s_ax <= t.ax; s_ay <= t.ay; s_bx <= t.bx; s_by_coord <= t.by_coord;
                    s_cx <= t.cx; s_cy <= t.cy; s_px <= t.px; s_py <= t.py;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                    if (!quiet_tail && pending_tris.size() > 0)
                        src_idle <= $urandom_range(1, 13) - 1;
                end
            end
        end
    end

    // Monitor: sink back-pressure plus comparison against oldest expectation.
    always @(posedge aclk) begin
        weights_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_weights.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word a=%h b=%h c=%h deg=%b",
                                 m_weight_a, m_weight_b, m_weight_c, m_degenerate);
                end else begin
                    want = expected_weights.pop_front();
                    if (m_weight_a !== want.wa || m_weight_b !== want.wb ||
                        m_weight_c !== want.wc || m_degenerate !== want.deg) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp a=%h b=%h c=%h deg=%b got a=%h b=%h c=%h deg=%b",
                                     want.wa, want.wb, want.wc, want.deg,
                                     m_weight_a, m_weight_b, m_weight_c, m_degenerate);
                    end
                end
            end
            if (sink_idle > 0) begin
                sink_idle <= sink_idle - 1;
                m_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 19) == 0) begin
                sink_idle <= $urandom_range(1, 13) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles without any handshake.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_MAX) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done && pending_tris.size() == 0);
        @(posedge aclk);
        while (s_valid) @(posedge aclk);
        while (expected_weights.size() > 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0 && expected_weights.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
